// File: rtl/core/gcd_pkg.sv
// ----------------------------------------------------------------------------
// gcd_pkg
// Shared widths, fixed-point constants and the CORDIC arctangent table of the
// great-circle distance pipeline.
// ----------------------------------------------------------------------------
package gcd_pkg;

   localparam int ANGLE_FRAC_BITS = 16;
   localparam int DIST_FRAC_BITS  = 8;
   localparam int Q               = 30;
   localparam int CORDIC_STEPS    = 30;

   localparam int LAT_W  = 24;
   localparam int LON_W  = 25;
   localparam int OUT_W  = 23;
   localparam int DEG_W  = 26;
   localparam int RAD_W  = 25;
   localparam int PROD_W = DEG_W + RAD_W;
   localparam int ANG_W  = 36;
   localparam int CW     = 34;
   localparam int ZW     = 33;
   localparam int ROOT_W = 31;

   localparam logic [RAD_W-1:0]        RAD_PER_DEG = 25'd18740330;
   localparam logic signed [ANG_W-1:0] PI_Q        = 36'sd3373259426;
   localparam logic signed [ANG_W-1:0] HALF_PI_Q   = 36'sd1686629713;
   localparam logic signed [ANG_W-1:0] TWO_PI_Q    = 36'sd6746518852;
   localparam logic signed [CW-1:0]    CORDIC_GAIN = 34'sd652032874;
   localparam logic [ROOT_W-1:0]       ONE_Q       = 31'd1073741824;
   localparam logic [13:0]             EARTH_DIAM  = 14'd12742;
   localparam logic [OUT_W-1:0]        OUT_MAX     = 23'h7FFFFF;

   function automatic logic signed [ZW-1:0] arc_tab(input logic [4:0] idx);
      logic signed [ZW-1:0] r;
      case (idx)
         5'd0:  r = 33'sd843314857;
         5'd1:  r = 33'sd497837829;
         5'd2:  r = 33'sd263043837;
         5'd3:  r = 33'sd133525159;
         5'd4:  r = 33'sd67021687;
         5'd5:  r = 33'sd33543516;
         5'd6:  r = 33'sd16775851;
         5'd7:  r = 33'sd8388437;
         5'd8:  r = 33'sd4194283;
         5'd9:  r = 33'sd2097149;
         5'd10: r = 33'sd1048576;
         5'd11: r = 33'sd524288;
         5'd12: r = 33'sd262144;
         5'd13: r = 33'sd131072;
         5'd14: r = 33'sd65536;
         5'd15: r = 33'sd32768;
         5'd16: r = 33'sd16384;
         5'd17: r = 33'sd8192;
         5'd18: r = 33'sd4096;
         5'd19: r = 33'sd2048;
         5'd20: r = 33'sd1024;
         5'd21: r = 33'sd512;
         5'd22: r = 33'sd256;
         5'd23: r = 33'sd128;
         5'd24: r = 33'sd64;
         5'd25: r = 33'sd32;
         5'd26: r = 33'sd16;
         5'd27: r = 33'sd8;
         5'd28: r = 33'sd4;
         5'd29: r = 33'sd2;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// File: rtl/core/gcd_if.sv
// ----------------------------------------------------------------------------
// gcd_req_if / gcd_rsp_if
// Valid/ready channels carrying point pairs in and distances out.
// ----------------------------------------------------------------------------
interface gcd_req_if;
   logic                               valid;
   logic                               ready;
   logic signed [gcd_pkg::LAT_W-1:0]   lat_a;
   logic signed [gcd_pkg::LON_W-1:0]   lon_a;
   logic signed [gcd_pkg::LAT_W-1:0]   lat_b;
   logic signed [gcd_pkg::LON_W-1:0]   lon_b;

   modport source (output valid, lat_a, lon_a, lat_b, lon_b, input ready);
   modport sink   (input valid, lat_a, lon_a, lat_b, lon_b, output ready);
endinterface

interface gcd_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [gcd_pkg::OUT_W-1:0]    distance_km;

   modport source (output valid, distance_km, input ready);
   modport sink   (input valid, distance_km, output ready);
endinterface

// File: rtl/core/gcd_sincos.sv
// ----------------------------------------------------------------------------
// gcd_sincos
// Pipelined rotation CORDIC: wraps and folds a Q30 angle, then one micro
// rotation per stage.
// ----------------------------------------------------------------------------
module gcd_sincos (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  logic signed [gcd_pkg::ANG_W-1:0]  angle,
   output logic                              out_valid,
   output logic signed [gcd_pkg::CW-1:0]     sin_q,
   output logic signed [gcd_pkg::CW-1:0]     cos_q
);
   localparam int STEPS = gcd_pkg::CORDIC_STEPS;
   localparam int CW    = gcd_pkg::CW;
   localparam int ZW    = gcd_pkg::ZW;
   localparam int ANG_W = gcd_pkg::ANG_W;

   logic signed [ANG_W-1:0] wrap_ff;
   logic                    wrap_vld_ff;
   logic signed [CW-1:0]    x_ff [0:STEPS];
   logic signed [CW-1:0]    y_ff [0:STEPS];
   logic signed [ZW-1:0]    z_ff [0:STEPS];
   logic                    flip_ff [0:STEPS];
   logic                    vld_ff [0:STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         wrap_vld_ff <= 1'b0;
         vld_ff[0]   <= 1'b0;
      end else if (en) begin
         wrap_vld_ff <= in_valid;
         vld_ff[0]   <= wrap_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (angle > gcd_pkg::PI_Q) begin
            wrap_ff <= angle - gcd_pkg::TWO_PI_Q;
         end else if (angle < -gcd_pkg::PI_Q) begin
            wrap_ff <= angle + gcd_pkg::TWO_PI_Q;
         end else begin
            wrap_ff <= angle;
         end
         // fold into the right half plane, cosine changes sign
         if (wrap_ff > gcd_pkg::HALF_PI_Q) begin
            z_ff[0]    <= ZW'(gcd_pkg::PI_Q - wrap_ff);
            flip_ff[0] <= 1'b1;
         end else if (wrap_ff < -gcd_pkg::HALF_PI_Q) begin
            z_ff[0]    <= ZW'(-gcd_pkg::PI_Q - wrap_ff);
            flip_ff[0] <= 1'b1;
         end else begin
            z_ff[0]    <= ZW'(wrap_ff);
            flip_ff[0] <= 1'b0;
         end
         x_ff[0] <= gcd_pkg::CORDIC_GAIN;
         y_ff[0] <= '0;
      end
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else if (en) begin
            vld_ff[i+1] <= vld_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            if (!z_ff[i][ZW-1]) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - gcd_pkg::arc_tab(5'(i));
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + gcd_pkg::arc_tab(5'(i));
            end
            flip_ff[i+1] <= flip_ff[i];
         end
      end
   end

   assign out_valid = vld_ff[STEPS];
   assign sin_q     = y_ff[STEPS];
   assign cos_q     = flip_ff[STEPS] ? -x_ff[STEPS] : x_ff[STEPS];

endmodule

// File: rtl/core/gcd_sqrt.sv
// ----------------------------------------------------------------------------
// gcd_sqrt
// Pipelined restoring square root of v * 2^30, one result bit per stage.
// ----------------------------------------------------------------------------
module gcd_sqrt (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic [gcd_pkg::ROOT_W-1:0]   v,
   output logic                         out_valid,
   output logic [gcd_pkg::ROOT_W-1:0]   root
);
   localparam int ROOT_W = gcd_pkg::ROOT_W;
   localparam int STEPS  = ROOT_W;
   localparam int NW     = 2 * ROOT_W;
   localparam int RW     = ROOT_W + 2;

   logic [NW-1:0]     n_ff   [0:STEPS];
   logic [RW-1:0]     rem_ff [0:STEPS];
   logic [ROOT_W-1:0] q_ff   [0:STEPS];
   logic              vld_ff [0:STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n_ff[0]   <= NW'({v, {gcd_pkg::Q{1'b0}}});
         rem_ff[0] <= '0;
         q_ff[0]   <= '0;
      end
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      logic [RW+1:0] rem_c;
      logic [RW+1:0] trial_c;

      // bring down the next two radicand bits, try root*4+1
      assign rem_c   = {rem_ff[i], n_ff[i][NW-1 -: 2]};
      assign trial_c = {2'b00, q_ff[i], 2'b01};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else if (en) begin
            vld_ff[i+1] <= vld_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            n_ff[i+1] <= n_ff[i] << 2;
            if (rem_c >= trial_c) begin
               rem_ff[i+1] <= RW'(rem_c - trial_c);
               q_ff[i+1]   <= {q_ff[i][ROOT_W-2:0], 1'b1};
            end else begin
               rem_ff[i+1] <= RW'(rem_c);
               q_ff[i+1]   <= {q_ff[i][ROOT_W-2:0], 1'b0};
            end
         end
      end
   end

   assign out_valid = vld_ff[STEPS];
   assign root      = q_ff[STEPS];

endmodule

// File: rtl/core/great_circle_distance_top.sv
// ----------------------------------------------------------------------------
// great_circle_distance_top
// Haversine distance between two points given in fixed-point degrees.
// ----------------------------------------------------------------------------
// req_bus carries one point pair per beat: lat_a, lon_a, lat_b, lon_b in
// degrees with 16 fraction bits. rsp_bus returns one beat per request,
// distance_km in kilometres with 8 fraction bits, in request order.
// The datapath is one pipeline of 103 register stages: input register,
// degree to radian multiply and round, four parallel rotation CORDICs
// (32 stages), three product and clamp stages, two parallel square roots
// (32 stages), a vectoring CORDIC (31 stages), a scale multiply and the
// output register. A new pair is accepted every cycle unless the output
// register holds an unaccepted beat and stalls the pipeline.
// The whole pipeline advances together: when the output register holds an
// unaccepted beat, req_bus.ready drops and every stage holds its contents,
// so nothing is lost or repeated. Reset (synchronous) clears all stage
// valid flags; the data registers are not reset.
// ----------------------------------------------------------------------------
module great_circle_distance_top (
   input  logic        clock,
   input  logic        reset,
   gcd_req_if.sink     req_bus,
   gcd_rsp_if.source   rsp_bus
);
   localparam int CW     = gcd_pkg::CW;
   localparam int ZW     = gcd_pkg::ZW;
   localparam int ANG_W  = gcd_pkg::ANG_W;
   localparam int DEG_W  = gcd_pkg::DEG_W;
   localparam int PROD_W = gcd_pkg::PROD_W;
   localparam int ROOT_W = gcd_pkg::ROOT_W;
   localparam int OUT_W  = gcd_pkg::OUT_W;
   localparam int LAT_W  = gcd_pkg::LAT_W;
   localparam int LON_W  = gcd_pkg::LON_W;
   localparam int Q      = gcd_pkg::Q;
   localparam int STEPS  = gcd_pkg::CORDIC_STEPS;
   localparam int DSH    = Q - gcd_pkg::DIST_FRAC_BITS;
   localparam int DP_W   = 46;

   logic adv;

   // input register
   logic signed [LAT_W-1:0] la_ff, lb_ff;
   logic signed [LON_W-1:0] oa_ff, ob_ff;
   logic                    s0_vld_ff;

   // degree magnitudes times radians per degree
   logic signed [DEG_W-1:0] deg_c  [0:3];
   logic [DEG_W-1:0]        mag_c  [0:3];
   logic [PROD_W-1:0]       rp_ff  [0:3];
   logic                    neg_ff [0:3];
   logic                    s1_vld_ff;

   logic signed [ANG_W-1:0] ang_ff [0:3];
   logic                    s2_vld_ff;

   logic signed [CW-1:0]    cos_a, cos_b, sin_hlat, sin_hlon;
   logic                    trig_vld;

   // haversine term
   logic signed [2*CW-1:0]  cc_c, sl_c, sa_c, cs_c;
   logic signed [CW-1:0]    cc_ff, sl_ff, sa_ff, cs_ff, sa2_ff;
   logic                    p1_vld_ff, p2_vld_ff;
   logic signed [CW-1:0]    sum_c;
   logic [ROOT_W-1:0]       a_ff, om_ff;
   logic                    p3_vld_ff;

   logic [ROOT_W-1:0]       root_x, root_y;
   logic                    sq_vld;

   // vectoring CORDIC
   logic signed [CW-1:0]    vx_ff  [0:STEPS];
   logic signed [CW-1:0]    vy_ff  [0:STEPS];
   logic signed [ZW-1:0]    vz_ff  [0:STEPS];
   logic                    vv_ff  [0:STEPS];

   logic [DP_W-1:0]         dp_ff;
   logic                    f1_vld_ff;
   logic [DP_W-1:0]         d_c;

   logic [OUT_W-1:0]        dist_ff;
   logic                    out_vld_ff;

   assign adv           = !out_vld_ff || rsp_bus.ready;
   assign req_bus.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         p1_vld_ff <= 1'b0;
         p2_vld_ff <= 1'b0;
         p3_vld_ff <= 1'b0;
         vv_ff[0]  <= 1'b0;
         f1_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         s0_vld_ff <= req_bus.valid;
         s1_vld_ff <= s0_vld_ff;
         s2_vld_ff <= s1_vld_ff;
         p1_vld_ff <= trig_vld;
         p2_vld_ff <= p1_vld_ff;
         p3_vld_ff <= p2_vld_ff;
         vv_ff[0]  <= sq_vld;
         f1_vld_ff <= vv_ff[STEPS];
         out_vld_ff <= f1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         la_ff <= req_bus.lat_a;
         oa_ff <= req_bus.lon_a;
         lb_ff <= req_bus.lat_b;
         ob_ff <= req_bus.lon_b;
      end
   end

   // differences are taken in degrees, then halved by one extra shift
   assign deg_c[0] = {{(DEG_W-LAT_W){la_ff[LAT_W-1]}}, la_ff};
   assign deg_c[1] = {{(DEG_W-LAT_W){lb_ff[LAT_W-1]}}, lb_ff};
   assign deg_c[2] = {{(DEG_W-LAT_W){lb_ff[LAT_W-1]}}, lb_ff}
                   - {{(DEG_W-LAT_W){la_ff[LAT_W-1]}}, la_ff};
   assign deg_c[3] = {{(DEG_W-LON_W){ob_ff[LON_W-1]}}, ob_ff}
                   - {{(DEG_W-LON_W){oa_ff[LON_W-1]}}, oa_ff};

   for (genvar k = 0; k < 4; k++) begin : g_lane
      localparam int SH = gcd_pkg::ANGLE_FRAC_BITS + ((k < 2) ? 0 : 1);
      logic [PROD_W-1:0] m_c;

      assign mag_c[k] = deg_c[k][DEG_W-1] ? DEG_W'(-deg_c[k]) : DEG_W'(deg_c[k]);
      assign m_c      = (rp_ff[k] + (PROD_W'(1) << (SH - 1))) >> SH;

      always_ff @(posedge clock) begin
         if (adv) begin
            rp_ff[k]  <= PROD_W'(mag_c[k]) * PROD_W'(gcd_pkg::RAD_PER_DEG);
            neg_ff[k] <= deg_c[k][DEG_W-1];
            ang_ff[k] <= neg_ff[k] ? -ANG_W'(m_c) : ANG_W'(m_c);
         end
      end
   end

   gcd_sincos u_trig_lat_a (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (s2_vld_ff),
      .angle     (ang_ff[0]),
      .out_valid (trig_vld),
      .sin_q     (),
      .cos_q     (cos_a)
   );

   gcd_sincos u_trig_lat_b (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (s2_vld_ff),
      .angle     (ang_ff[1]),
      .out_valid (),
      .sin_q     (),
      .cos_q     (cos_b)
   );

   gcd_sincos u_trig_dlat (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (s2_vld_ff),
      .angle     (ang_ff[2]),
      .out_valid (),
      .sin_q     (sin_hlat),
      .cos_q     ()
   );

   gcd_sincos u_trig_dlon (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (s2_vld_ff),
      .angle     (ang_ff[3]),
      .out_valid (),
      .sin_q     (sin_hlon),
      .cos_q     ()
   );

   assign cc_c = cos_a * cos_b;
   assign sl_c = sin_hlon * sin_hlon;
   assign sa_c = sin_hlat * sin_hlat;
   assign cs_c = cc_ff * sl_ff;
   assign sum_c = cs_ff + sa2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         cc_ff  <= CW'(cc_c >>> Q);
         sl_ff  <= CW'(sl_c >>> Q);
         sa_ff  <= CW'(sa_c >>> Q);
         cs_ff  <= CW'(cs_c >>> Q);
         sa2_ff <= sa_ff;
         // clamp to [0, 1] in Q30
         if (sum_c[CW-1]) begin
            a_ff  <= '0;
            om_ff <= gcd_pkg::ONE_Q;
         end else if (sum_c > $signed({3'b000, gcd_pkg::ONE_Q})) begin
            a_ff  <= gcd_pkg::ONE_Q;
            om_ff <= '0;
         end else begin
            a_ff  <= ROOT_W'(sum_c);
            om_ff <= gcd_pkg::ONE_Q - ROOT_W'(sum_c);
         end
      end
   end

   gcd_sqrt u_sqrt_x (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (p3_vld_ff),
      .v         (om_ff),
      .out_valid (sq_vld),
      .root      (root_x)
   );

   gcd_sqrt u_sqrt_y (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (p3_vld_ff),
      .v         (a_ff),
      .out_valid (),
      .root      (root_y)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         vx_ff[0] <= $signed({{(CW-ROOT_W){1'b0}}, root_x});
         vy_ff[0] <= $signed({{(CW-ROOT_W){1'b0}}, root_y});
         vz_ff[0] <= '0;
      end
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_vec
      logic y_pos;

      assign y_pos = !vy_ff[i][CW-1] && (vy_ff[i] != '0);

      always_ff @(posedge clock) begin
         if (reset) begin
            vv_ff[i+1] <= 1'b0;
         end else if (adv) begin
            vv_ff[i+1] <= vv_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            if (y_pos) begin
               vx_ff[i+1] <= vx_ff[i] + (vy_ff[i] >>> i);
               vy_ff[i+1] <= vy_ff[i] - (vx_ff[i] >>> i);
               vz_ff[i+1] <= vz_ff[i] + gcd_pkg::arc_tab(5'(i));
            end else begin
               vx_ff[i+1] <= vx_ff[i] - (vy_ff[i] >>> i);
               vy_ff[i+1] <= vy_ff[i] + (vx_ff[i] >>> i);
               vz_ff[i+1] <= vz_ff[i] - gcd_pkg::arc_tab(5'(i));
            end
         end
      end
   end

   // negative angle counts as zero distance
   assign d_c = (dp_ff + (DP_W'(1) << (DSH - 1))) >> DSH;

   always_ff @(posedge clock) begin
      if (adv) begin
         if (vz_ff[STEPS][ZW-1]) begin
            dp_ff <= '0;
         end else begin
            dp_ff <= DP_W'(vz_ff[STEPS][ZW-2:0]) * DP_W'(gcd_pkg::EARTH_DIAM);
         end
         if (d_c > DP_W'(gcd_pkg::OUT_MAX)) begin
            dist_ff <= gcd_pkg::OUT_MAX;
         end else begin
            dist_ff <= OUT_W'(d_c);
         end
      end
   end

   assign rsp_bus.valid       = out_vld_ff;
   assign rsp_bus.distance_km = dist_ff;

endmodule
